>>> rtl/segment_cost_dp_hull_defines.svh
// ----------------------------------------------------------------------------
// Segment cost DP hull: assertion macros
// Shared property forms for the block's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef SEGMENT_COST_DP_HULL_DEFINES_SVH
`define SEGMENT_COST_DP_HULL_DEFINES_SVH

// condition holds at every edge outside reset
`define SCDH_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// antecedent implies consequent on the following edge
`define SCDH_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/scdh_pkg.sv
// ----------------------------------------------------------------------------
// scdh_pkg
// Shared constants and sequencer state type of the segment cost DP hull.
// ----------------------------------------------------------------------------
`default_nettype none

package scdh_pkg;

   localparam int MAX_WORDS_DEF = 4096;
   localparam int WORD_W        = 10;
   localparam int COST_W        = 16;
   localparam int BEST_W        = 45;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_SQ,
      ST_H0,
      ST_H0A,
      ST_H1,
      ST_H1A,
      ST_HC,
      ST_DP,
      ST_B,
      ST_EQ,
      ST_P0,
      ST_P1,
      ST_P2,
      ST_M0,
      ST_M1,
      ST_M2,
      ST_M3,
      ST_M4,
      ST_CMP,
      ST_PUSH,
      ST_OUT
   } state_type;

endpackage

`default_nettype wire

>>> rtl/scdh_mul.sv
// ----------------------------------------------------------------------------
// scdh_mul
// Shared unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
`default_nettype none

module scdh_mul #(
   parameter int MUL_W = 24
) (
   input  wire logic               clock,
   input  wire logic [MUL_W-1:0]   op_a,
   input  wire logic [MUL_W-1:0]   op_b,
   output logic      [2*MUL_W-1:0] prod
);

   logic [2*MUL_W-1:0] prod_ff;
   logic [2*MUL_W-1:0] prod_in;

   assign prod_in = op_a * op_b;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

`default_nettype wire

>>> rtl/scdh_line_ram.sv
// ----------------------------------------------------------------------------
// scdh_line_ram
// Line deque storage: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module scdh_line_ram #(
   parameter int DEPTH  = 4097,
   parameter int ADDR_W = 13,
   parameter int DATA_W = 70
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [DATA_W-1:0] wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // hold read data until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> rtl/segment_cost_dp_hull.sv
// ----------------------------------------------------------------------------
// segment_cost_dp_hull
// Flow: each request runs front-line tests, then back-line tests; an equal-slope line
//   that is dropped skips the back-line tests, and an overflowed request goes straight
//   to the result. Every product uses the one multiplier.
// Throughput: one request at a time; the next is accepted once the result is out.
// Reset: synchronous; clears line_cost and starts a fresh run; deque storage
//   is not cleared (entry 0 is written when a run starts).
// ----------------------------------------------------------------------------
`default_nettype none

`include "segment_cost_dp_hull_defines.svh"

module segment_cost_dp_hull #(
   parameter int MAX_WORDS = scdh_pkg::MAX_WORDS_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        csr_we,
   input  wire logic [scdh_pkg::COST_W-1:0] csr_wdata,
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire logic [scdh_pkg::WORD_W-1:0] req_word_cost,
   input  wire logic                        req_first_word,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output logic      [scdh_pkg::BEST_W-1:0] rsp_best_cost,
   output logic                             rsp_overflow
);

   localparam int CNT_W    = $clog2(MAX_WORDS + 1);
   localparam int SUM_W    = scdh_pkg::WORD_W + $clog2(MAX_WORDS);
   localparam int SLOPE_W  = SUM_W + 1;
   localparam int MUL_W    = SUM_W + 2;
   localparam int SQ_W     = 2 * SUM_W;
   localparam int DP_W     = 2 * SUM_W + 1;
   localparam int IC_W     = 2 * SUM_W + 3;
   localparam int EV_W     = IC_W + 1;
   localparam int MAG_W    = 2 * MUL_W;
   localparam int ACC_W    = 3 * MUL_W;
   localparam int DEQ_SIZE = MAX_WORDS + 1;
   localparam int IDX_W    = $clog2(DEQ_SIZE + 1);
   localparam int ADDR_W   = $clog2(DEQ_SIZE);
   localparam int LINE_W   = SLOPE_W + IC_W;
   localparam int BEST_W   = scdh_pkg::BEST_W;
   localparam int COST_W   = scdh_pkg::COST_W;

   scdh_pkg::state_type state_ff, state_in;

   logic                    fresh_ff, fresh_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic [SUM_W-1:0]        x_ff, x_in;
   logic [IDX_W-1:0]        head_ff, head_in;
   logic [IDX_W-1:0]        tail_ff, tail_in;
   logic                    run_ovf_ff, run_ovf_in;
   logic                    res_ovf_ff, res_ovf_in;
   logic [COST_W-1:0]       line_cost_ff, line_cost_in;
   logic [SQ_W-1:0]         sq_ff, sq_in;
   logic signed [EV_W-1:0]  v0_ff, v0_in;
   logic signed [EV_W-1:0]  v1_ff, v1_in;
   logic [DP_W-1:0]         dp_ff, dp_in;
   logic signed [IC_W-1:0]  b_ff, b_in;
   logic [SLOPE_W-1:0]      l2_slope_ff, l2_slope_in;
   logic signed [IC_W-1:0]  l2_icpt_ff, l2_icpt_in;
   logic                    pneg_ff, pneg_in;
   logic                    qneg_ff, qneg_in;
   logic [MAG_W-1:0]        pmag_ff, pmag_in;
   logic [MAG_W-1:0]        qmag_ff, qmag_in;
   logic [SLOPE_W-1:0]      da_ff, da_in;
   logic [SLOPE_W-1:0]      db_ff, db_in;
   logic [ACC_W-1:0]        acc_a_ff, acc_a_in;
   logic [ACC_W-1:0]        acc_b_ff, acc_b_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [BEST_W-1:0]       rsp_best_ff, rsp_best_in;
   logic                    rsp_ovf_ff, rsp_ovf_in;

   logic                    accept;
   logic                    start;
   logic [CNT_W-1:0]        eff_cnt;
   logic [SUM_W-1:0]        eff_sum;
   logic                    is_ovf;
   logic [IDX_W-1:0]        occ;
   logic                    multi;
   logic                    more_front;
   logic [SLOPE_W-1:0]      slope_a;
   logic                    out_free;
   logic                    front_le;
   logic                    eq_drop;
   logic                    eq_replace;
   logic                    back_le;
   logic                    push_room;
   logic                    back_test;
   logic                    run_begin;
   logic                    deq_fresh;

   logic                    mem_we, mem_re;
   logic [IDX_W-1:0]        mem_waddr, mem_raddr;
   logic [LINE_W-1:0]       mem_wdata, mem_rdata;
   logic [SLOPE_W-1:0]      rd_slope;
   logic signed [IC_W-1:0]  rd_icpt;
   logic [MUL_W-1:0]        mul_a, mul_b;
   logic [2*MUL_W-1:0]      mul_prod;

   logic signed [EV_W-1:0]  line_val;
   logic signed [EV_W:0]    dp_sum;
   logic signed [IC_W:0]    p_diff, q_diff;
   logic [DP_W+BEST_W-1:0]  dp_ext;

   scdh_line_ram #(
      .DEPTH  (DEQ_SIZE),
      .ADDR_W (ADDR_W),
      .DATA_W (LINE_W)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr[ADDR_W-1:0]),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr[ADDR_W-1:0]),
      .rd_data (mem_rdata)
   );

   scdh_mul #(
      .MUL_W (MUL_W)
   ) u_mul (
      .clock (clock),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .prod  (mul_prod)
   );

   assign rd_slope = mem_rdata[LINE_W-1:IC_W];
   assign rd_icpt  = $signed(mem_rdata[IC_W-1:0]);

   assign accept     = req_valid & ~req_stall;
   assign start      = req_first_word | fresh_ff;
   assign eff_cnt    = start ? '0 : cnt_ff;
   assign eff_sum    = start ? '0 : x_ff;
   assign is_ovf     = (~start & run_ovf_ff) | (eff_cnt >= CNT_W'(MAX_WORDS));
   assign occ        = tail_ff - head_ff;
   assign multi      = occ > IDX_W'(1);
   assign more_front = occ > IDX_W'(2);
   assign slope_a    = {x_ff, 1'b0};
   assign out_free   = ~rsp_valid_ff | ~rsp_stall;
   assign front_le   = v0_ff <= v1_ff;
   assign eq_drop    = (rd_slope == slope_a) && (rd_icpt >= b_ff);
   assign eq_replace = (rd_slope == slope_a) && (rd_icpt < b_ff);
   assign back_le    = (pneg_ff != qneg_ff) ? pneg_ff :
                       (pneg_ff ? (acc_a_ff >= acc_b_ff) : (acc_a_ff <= acc_b_ff));
   assign push_room  = tail_ff < IDX_W'(DEQ_SIZE);
   assign back_test  = state_ff == scdh_pkg::ST_CMP;
   assign run_begin  = accept & req_first_word;
   assign deq_fresh  = (head_ff == '0) && (tail_ff == IDX_W'(1));

   // value of the line in the read register at x
   assign line_val = $signed({1'b0, mul_prod[EV_W-2:0]})
                   + $signed({{(EV_W-IC_W){rd_icpt[IC_W-1]}}, rd_icpt});
   assign dp_sum   = $signed({2'b00, {(EV_W-1-SQ_W){1'b0}}, sq_ff})
                   - $signed({v0_ff[EV_W-1], v0_ff})
                   + $signed({{(EV_W+1-COST_W){1'b0}}, line_cost_ff});
   assign p_diff   = $signed({l2_icpt_ff[IC_W-1], l2_icpt_ff})
                   - $signed({b_ff[IC_W-1], b_ff});
   assign q_diff   = $signed({rd_icpt[IC_W-1], rd_icpt})
                   - $signed({l2_icpt_ff[IC_W-1], l2_icpt_ff});
   assign dp_ext   = {{BEST_W{1'b0}}, dp_ff};

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         scdh_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = is_ovf ? scdh_pkg::ST_OUT : scdh_pkg::ST_SQ;
            end
         end
         scdh_pkg::ST_SQ:   state_in = scdh_pkg::ST_H0;
         scdh_pkg::ST_H0:   state_in = scdh_pkg::ST_H0A;
         scdh_pkg::ST_H0A:  state_in = multi ? scdh_pkg::ST_H1 : scdh_pkg::ST_DP;
         scdh_pkg::ST_H1:   state_in = scdh_pkg::ST_H1A;
         scdh_pkg::ST_H1A:  state_in = scdh_pkg::ST_HC;
         scdh_pkg::ST_HC: begin
            state_in = (front_le && more_front) ? scdh_pkg::ST_H1 : scdh_pkg::ST_DP;
         end
         scdh_pkg::ST_DP:   state_in = scdh_pkg::ST_B;
         scdh_pkg::ST_B:    state_in = scdh_pkg::ST_EQ;
         scdh_pkg::ST_EQ:   state_in = eq_drop ? scdh_pkg::ST_OUT : scdh_pkg::ST_P0;
         scdh_pkg::ST_P0:   state_in = multi ? scdh_pkg::ST_P1 : scdh_pkg::ST_PUSH;
         scdh_pkg::ST_P1:   state_in = scdh_pkg::ST_P2;
         scdh_pkg::ST_P2:   state_in = scdh_pkg::ST_M0;
         scdh_pkg::ST_M0:   state_in = scdh_pkg::ST_M1;
         scdh_pkg::ST_M1:   state_in = scdh_pkg::ST_M2;
         scdh_pkg::ST_M2:   state_in = scdh_pkg::ST_M3;
         scdh_pkg::ST_M3:   state_in = scdh_pkg::ST_M4;
         scdh_pkg::ST_M4:   state_in = scdh_pkg::ST_CMP;
         scdh_pkg::ST_CMP:  state_in = back_le ? scdh_pkg::ST_P0 : scdh_pkg::ST_PUSH;
         scdh_pkg::ST_PUSH: state_in = scdh_pkg::ST_OUT;
         scdh_pkg::ST_OUT:  state_in = out_free ? scdh_pkg::ST_IDLE : scdh_pkg::ST_OUT;
         default:           state_in = scdh_pkg::ST_IDLE;
      endcase
   end

   // memory and multiplier controls
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = '0;
      mem_wdata = '0;
      mem_re    = 1'b0;
      mem_raddr = '0;
      mul_a     = '0;
      mul_b     = '0;
      case (state_ff)
         scdh_pkg::ST_IDLE: begin
            // place the start line at entry 0
            if (accept && start) begin
               mem_we = 1'b1;
            end
         end
         scdh_pkg::ST_SQ: begin
            mul_a     = MUL_W'(x_ff);
            mul_b     = MUL_W'(x_ff);
            mem_re    = 1'b1;
            mem_raddr = head_ff;
         end
         scdh_pkg::ST_H0, scdh_pkg::ST_H1: begin
            mul_a = MUL_W'(rd_slope);
            mul_b = MUL_W'(x_ff);
         end
         scdh_pkg::ST_H0A: begin
            mem_re    = multi;
            mem_raddr = head_ff + IDX_W'(1);
         end
         scdh_pkg::ST_HC: begin
            mem_re    = front_le && more_front;
            mem_raddr = head_ff + IDX_W'(2);
         end
         scdh_pkg::ST_DP: begin
            mem_re    = 1'b1;
            mem_raddr = tail_ff - IDX_W'(1);
         end
         scdh_pkg::ST_P0: begin
            mem_re    = multi;
            mem_raddr = tail_ff - IDX_W'(1);
         end
         scdh_pkg::ST_P1: begin
            mem_re    = 1'b1;
            mem_raddr = tail_ff - IDX_W'(2);
         end
         scdh_pkg::ST_M0: begin
            mul_a = pmag_ff[MUL_W-1:0];
            mul_b = MUL_W'(da_ff);
         end
         scdh_pkg::ST_M1: begin
            mul_a = pmag_ff[MAG_W-1:MUL_W];
            mul_b = MUL_W'(da_ff);
         end
         scdh_pkg::ST_M2: begin
            mul_a = qmag_ff[MUL_W-1:0];
            mul_b = MUL_W'(db_ff);
         end
         scdh_pkg::ST_M3: begin
            mul_a = qmag_ff[MAG_W-1:MUL_W];
            mul_b = MUL_W'(db_ff);
         end
         scdh_pkg::ST_PUSH: begin
            mem_we    = push_room;
            mem_waddr = tail_ff;
            mem_wdata = {slope_a, b_ff};
         end
         default: begin
            mem_we = 1'b0;
         end
      endcase
   end

   // datapath next values
   always_comb begin
      fresh_in     = fresh_ff;
      cnt_in       = cnt_ff;
      x_in         = x_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      run_ovf_in   = run_ovf_ff;
      res_ovf_in   = res_ovf_ff;
      line_cost_in = csr_we ? csr_wdata : line_cost_ff;
      sq_in        = sq_ff;
      v0_in        = v0_ff;
      v1_in        = v1_ff;
      dp_in        = dp_ff;
      b_in         = b_ff;
      l2_slope_in  = l2_slope_ff;
      l2_icpt_in   = l2_icpt_ff;
      pneg_in      = pneg_ff;
      qneg_in      = qneg_ff;
      pmag_in      = pmag_ff;
      qmag_in      = qmag_ff;
      da_in        = da_ff;
      db_in        = db_ff;
      acc_a_in     = acc_a_ff;
      acc_b_in     = acc_b_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      rsp_best_in  = rsp_best_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      case (state_ff)
         scdh_pkg::ST_IDLE: begin
            if (accept) begin
               fresh_in = 1'b0;
               if (start) begin
                  head_in = '0;
                  tail_in = IDX_W'(1);
               end
               if (is_ovf) begin
                  run_ovf_in = 1'b1;
                  res_ovf_in = 1'b1;
                  cnt_in     = eff_cnt;
                  x_in       = eff_sum;
               end else begin
                  run_ovf_in = 1'b0;
                  res_ovf_in = 1'b0;
                  cnt_in     = eff_cnt + CNT_W'(1);
                  x_in       = eff_sum + SUM_W'(req_word_cost);
               end
            end
         end
         scdh_pkg::ST_H0:   sq_in = mul_prod[SQ_W-1:0];
         scdh_pkg::ST_H0A:  v0_in = line_val;
         scdh_pkg::ST_H1A:  v1_in = line_val;
         scdh_pkg::ST_HC: begin
            // advance the front while the next line is at least as good
            if (front_le) begin
               head_in = head_ff + IDX_W'(1);
               v0_in   = v1_ff;
            end
         end
         scdh_pkg::ST_DP:   dp_in = dp_sum[DP_W-1:0];
         scdh_pkg::ST_B: begin
            b_in = -$signed({2'b00, dp_ff} + {{(IC_W-SQ_W){1'b0}}, sq_ff});
         end
         scdh_pkg::ST_EQ: begin
            if (eq_replace) begin
               tail_in = tail_ff - IDX_W'(1);
            end
         end
         scdh_pkg::ST_P1: begin
            l2_slope_in = rd_slope;
            l2_icpt_in  = rd_icpt;
         end
         scdh_pkg::ST_P2: begin
            pneg_in = p_diff[IC_W];
            qneg_in = q_diff[IC_W];
            pmag_in = p_diff[IC_W] ? MAG_W'(-p_diff) : MAG_W'(p_diff);
            qmag_in = q_diff[IC_W] ? MAG_W'(-q_diff) : MAG_W'(q_diff);
            da_in   = l2_slope_ff - rd_slope;
            db_in   = slope_a - l2_slope_ff;
         end
         scdh_pkg::ST_M1:   acc_a_in = ACC_W'(mul_prod);
         scdh_pkg::ST_M2:   acc_a_in = acc_a_ff + {mul_prod, {MUL_W{1'b0}}};
         scdh_pkg::ST_M3:   acc_b_in = ACC_W'(mul_prod);
         scdh_pkg::ST_M4:   acc_b_in = acc_b_ff + {mul_prod, {MUL_W{1'b0}}};
         scdh_pkg::ST_CMP: begin
            // drop the back line when the new line takes over no later
            if (back_le) begin
               tail_in = tail_ff - IDX_W'(1);
            end
         end
         scdh_pkg::ST_PUSH: begin
            if (push_room) begin
               tail_in = tail_ff + IDX_W'(1);
            end
         end
         scdh_pkg::ST_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_ovf_in   = res_ovf_ff;
               rsp_best_in  = res_ovf_ff ? '0 : dp_ext[BEST_W-1:0];
            end
         end
         default: begin
            rsp_valid_in = rsp_valid_ff & rsp_stall;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= scdh_pkg::ST_IDLE;
         fresh_ff     <= 1'b1;
         cnt_ff       <= '0;
         x_ff         <= '0;
         head_ff      <= '0;
         tail_ff      <= IDX_W'(1);
         run_ovf_ff   <= 1'b0;
         line_cost_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fresh_ff     <= fresh_in;
         cnt_ff       <= cnt_in;
         x_ff         <= x_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         run_ovf_ff   <= run_ovf_in;
         line_cost_ff <= line_cost_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      res_ovf_ff  <= res_ovf_in;
      sq_ff       <= sq_in;
      v0_ff       <= v0_in;
      v1_ff       <= v1_in;
      dp_ff       <= dp_in;
      b_ff        <= b_in;
      l2_slope_ff <= l2_slope_in;
      l2_icpt_ff  <= l2_icpt_in;
      pneg_ff     <= pneg_in;
      qneg_ff     <= qneg_in;
      pmag_ff     <= pmag_in;
      qmag_ff     <= qmag_in;
      da_ff       <= da_in;
      db_ff       <= db_in;
      acc_a_ff    <= acc_a_in;
      acc_b_ff    <= acc_b_in;
      rsp_best_ff <= rsp_best_in;
      rsp_ovf_ff  <= rsp_ovf_in;
   end

   assign req_stall     = state_ff != scdh_pkg::ST_IDLE;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_best_cost = rsp_best_ff;
   assign rsp_overflow  = rsp_ovf_ff;

   `SCDH_ASSERT_ALWAYS(a_head_le_tail, clock, reset, head_ff <= tail_ff, "head passed tail")
   `SCDH_ASSERT_ALWAYS(a_tail_bound, clock, reset, tail_ff <= IDX_W'(DEQ_SIZE), "tail past end")
   `SCDH_ASSERT_ALWAYS(a_pop_two, clock, reset, !back_test || multi, "back pop with one line")
   `SCDH_ASSERT_NEXT(a_run_start, clock, reset, run_begin, deq_fresh, "deque not restarted")

endmodule

`default_nettype wire

>>> sim/tb_segment_cost_dp_hull.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_segment_cost_dp_hull
// Self-checking bench for the segment cost DP hull. A behavioral copy of the
// min-cost grouping recurrence (exact line deque) predicts the results, and typed
// rows of a directed table give their own; the table covers extremes and edge cases,
// then random runs, several line_cost settings and a receiver hold-off.
// ----------------------------------------------------------------------------

module tb_segment_cost_dp_hull;

   localparam int MAXW       = scdh_pkg::MAX_WORDS_DEF;
   localparam int HULL_DEPTH = MAXW + 1;
   localparam int CYCLE_CAP  = 1500000;
   localparam int DRAIN_WAIT = 40;
   localparam int EXP_DEPTH  = 16;
   localparam int DIRECTED_N = 22;

   typedef struct {
      logic [scdh_pkg::BEST_W-1:0] best;
      logic                        ovf;
   } cost_result_type;

   typedef struct {
      logic [scdh_pkg::WORD_W-1:0] word;
      logic                        first;
      bit                          typed;
      logic [scdh_pkg::BEST_W-1:0] best;
      logic                        ovf;
   } word_row_type;

   logic                          clock = 1'b0;
   logic                          reset;
   logic                          csr_we;
   logic [scdh_pkg::COST_W-1:0]   csr_wdata;
   logic                          req_valid;
   logic                          req_stall;
   logic [scdh_pkg::WORD_W-1:0]   req_word_cost;
   logic                          req_first_word;
   logic                          rsp_valid;
   logic                          rsp_stall;
   logic [scdh_pkg::BEST_W-1:0]   rsp_best_cost;
   logic                          rsp_overflow;

   segment_cost_dp_hull DUT (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_wdata      (csr_wdata),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_word_cost  (req_word_cost),
      .req_first_word (req_first_word),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_best_cost  (rsp_best_cost),
      .rsp_overflow   (rsp_overflow)
   );

   // predictor state
   longint          run_total;
   int              run_words;
   bit              run_over;
   longint          hull_slope [HULL_DEPTH];
   longint          hull_icpt  [HULL_DEPTH];
   int              hull_head;
   int              hull_tail;
   longint          group_cost;

   cost_result_type expect_store [EXP_DEPTH];
   int              exp_wr;
   int              exp_rd;
   int              fail_count;
   int              cycle_count;
   int              send_idle_pct;
   int              recv_idle_pct;
   bit              hold_go;
   int              hold_left;

   word_row_type directed_rows [DIRECTED_N] = '{
      '{10'd5,    1'b0, 1'b1, 45'd25,      1'b0},
      '{10'd3,    1'b0, 1'b0, 45'd0,       1'b0},
      '{10'd3,    1'b0, 1'b0, 45'd0,       1'b0},
      '{10'd1023, 1'b1, 1'b1, 45'd1046529, 1'b0},
      '{10'd1023, 1'b0, 1'b0, 45'd0,       1'b0},
      '{10'd1023, 1'b0, 1'b0, 45'd0,       1'b0},
      '{10'd0,    1'b1, 1'b1, 45'd0,       1'b0},
      '{10'd0,    1'b0, 1'b1, 45'd0,       1'b0},
      '{10'd7,    1'b1, 1'b0, 45'd0,       1'b0},
      '{10'd0,    1'b0, 1'b0, 45'd0,       1'b0},
      '{10'd0,    1'b0, 1'b0, 45'd0,       1'b0},
      '{10'd512,  1'b0, 1'b0, 45'd0,       1'b0},
      '{10'd1,    1'b0, 1'b0, 45'd0,       1'b0},
      '{10'd2,    1'b0, 1'b0, 45'd0,       1'b0},
      '{10'd4,    1'b0, 1'b0, 45'd0,       1'b0},
      '{10'd8,    1'b0, 1'b0, 45'd0,       1'b0},
      '{10'd16,   1'b0, 1'b0, 45'd0,       1'b0},
      '{10'd32,   1'b0, 1'b0, 45'd0,       1'b0},
      '{10'd64,   1'b0, 1'b0, 45'd0,       1'b0},
      '{10'd128,  1'b0, 1'b0, 45'd0,       1'b0},
      '{10'd256,  1'b0, 1'b0, 45'd0,       1'b0},
      '{10'd0,    1'b0, 1'b0, 45'd0,       1'b0}
   };

   initial begin
      forever #10 clock = ~clock;
   end

   function automatic void restart_run();
      run_total  = 0;
      run_words  = 0;
      run_over   = 1'b0;
      hull_head  = 0;
      hull_tail  = 1;
      hull_slope[0] = 0;
      hull_icpt[0]  = 0;
   endfunction

   function automatic longint line_at(int k, longint x);
      return hull_slope[k] * x + hull_icpt[k];
   endfunction

   // advance the grouping recurrence by one word and return its result
   function automatic cost_result_type group_step(logic [scdh_pkg::WORD_W-1:0] word,
                                                  logic first);
      cost_result_type     res;
      longint              x, best, dp, a, b;
      logic signed [127:0] p1, q1, p2, q2;
      bit                  dropped;
      if (first)
         restart_run();
      if (run_over || run_words >= MAXW) begin
         run_over = 1'b1;
         res.best = '0;
         res.ovf  = 1'b1;
         return res;
      end
      run_words++;
      run_total += word;
      x = run_total;
      while (hull_tail - hull_head > 1 &&
             line_at(hull_head, x) <= line_at(hull_head + 1, x))
         hull_head++;
      best = line_at(hull_head, x);
      dp = -best + group_cost + x * x;
      a = 2 * x;
      b = -(dp + x * x);
      dropped = 1'b0;
      if (hull_tail > hull_head && hull_slope[hull_tail-1] == a) begin
         if (hull_icpt[hull_tail-1] >= b)
            dropped = 1'b1;
         else
            hull_tail--;
      end
      if (!dropped) begin
         while (hull_tail - hull_head > 1) begin
            p1 = hull_icpt[hull_tail-1] - b;
            q1 = hull_slope[hull_tail-1] - hull_slope[hull_tail-2];
            p2 = hull_icpt[hull_tail-2] - hull_icpt[hull_tail-1];
            q2 = a - hull_slope[hull_tail-1];
            if (p1 * q1 <= p2 * q2)
               hull_tail--;
            else
               break;
         end
         if (hull_tail < HULL_DEPTH) begin
            hull_slope[hull_tail] = a;
            hull_icpt[hull_tail]  = b;
            hull_tail++;
         end
      end
      res.best = dp[scdh_pkg::BEST_W-1:0];
      res.ovf  = 1'b0;
      return res;
   endfunction

   task automatic send_word(word_row_type row);
      cost_result_type res;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_word_cost  <= row.word;
      req_first_word <= row.first;
      do @(posedge clock); while (req_stall);
      res = group_step(row.word, row.first);
      if (row.typed) begin
         res.best = row.best;
         res.ovf  = row.ovf;
      end
      expect_store[exp_wr % EXP_DEPTH] = res;
      exp_wr++;
   endtask

   // write line_cost once the block has drained
   task automatic set_line_cost(logic [scdh_pkg::COST_W-1:0] value);
      req_valid <= 1'b0;
      while (exp_wr != exp_rd)
         @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we     <= 1'b0;
      group_cost = value;
   endtask

   task automatic random_runs(int count, int first_pct);
      word_row_type row;
      int           pick;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(9);
         case (pick)
            0: row.word = '0;
            1: row.word = '1;
            2, 3, 4: row.word = scdh_pkg::WORD_W'($urandom_range(15));
            default: row.word = scdh_pkg::WORD_W'($urandom_range(1023));
         endcase
         row.first = ($urandom_range(99) < first_pct);
         row.typed = 1'b0;
         send_word(row);
      end
   endtask

   // receiver: random stall, plus one long hold-off on request
   initial begin
      rsp_stall = 1'b1;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (hold_go) begin
            hold_go   = 1'b0;
            hold_left = 400;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      cost_result_type exp_res;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (exp_wr == exp_rd) begin
            $error("result with nothing expected: best_cost %0d", rsp_best_cost);
            fail_count++;
         end else begin
            exp_res = expect_store[exp_rd % EXP_DEPTH];
            exp_rd++;
            if (rsp_best_cost !== exp_res.best) begin
               $error("best_cost expected %0d actual %0d", exp_res.best, rsp_best_cost);
               fail_count++;
            end
            if (rsp_overflow !== exp_res.ovf) begin
               $error("overflow expected %0d actual %0d", exp_res.ovf, rsp_overflow);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_CAP) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin
      word_row_type row;
      reset          = 1'b1;
      csr_we         = 1'b0;
      csr_wdata      = '0;
      req_valid      = 1'b0;
      req_word_cost  = '0;
      req_first_word = 1'b0;
      exp_wr         = 0;
      exp_rd         = 0;
      fail_count     = 0;
      cycle_count    = 0;
      send_idle_pct  = 8;
      recv_idle_pct  = 8;
      hold_go        = 1'b0;
      group_cost     = 0;
      for (int k = 0; k < HULL_DEPTH; k++) begin
         hull_slope[k] = 0;
         hull_icpt[k]  = 0;
      end
      restart_run();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i])
         send_word(directed_rows[i]);

      set_line_cost(16'hFFFF);
      random_runs(200, 3);

      // stall the result side while requests keep coming
      hold_go = 1'b1;
      random_runs(150, 3);

      set_line_cost(16'h0000);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      random_runs(300, 2);
      send_idle_pct = 8;
      recv_idle_pct = 8;

      set_line_cost(scdh_pkg::COST_W'($urandom_range(65535)));
      random_runs(300, 5);

      set_line_cost(16'h0001);
      random_runs(300, 1);

      // a fresh run under a larger line cost
      set_line_cost(16'd300);
      random_runs(20, 0);
      row.word  = 10'd9;
      row.first = 1'b1;
      row.typed = 1'b0;
      send_word(row);
      random_runs(20, 0);

      req_valid <= 1'b0;
      while (exp_wr != exp_rd)
         @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (fail_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

>>> files.f
+incdir+rtl
rtl/scdh_pkg.sv
rtl/scdh_mul.sv
rtl/scdh_line_ram.sv
rtl/segment_cost_dp_hull.sv
sim/tb_segment_cost_dp_hull.sv
